### hdl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometer compensation pipeline:
// calibration word bundle, register indexes, stage count and output limits.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Pipeline depth, from input register to output register
  localparam int NUM_STAGES = 9;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SENS_COEFF    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COEFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMPCO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_TEMPCO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SLOPE    = 3'd5;

  // Field widths
  localparam int RAW_W  = 24;
  localparam int TEMP_W = 15;
  localparam int PRES_W = 17;

  // Output limits
  localparam logic signed [19:0] TEMP_MIN = -20'sd4000;
  localparam logic signed [19:0] TEMP_MAX = 20'sd8500;
  localparam logic [27:0]        PRES_MAX = 28'd120000;

  // Reference point of the temperature scale (20.00 degC) and the
  // low-temperature knee distance (20.00 - -15.00 degC)
  localparam logic [19:0] TEMP_REF  = 20'd2000;
  localparam logic [18:0] LOW_KNEE  = 19'd3500;

  // Calibration words
  typedef struct packed {
    logic [CFG_DATA_W-1:0] sens_coeff;
    logic [CFG_DATA_W-1:0] offset_coeff;
    logic [CFG_DATA_W-1:0] sens_tempco;
    logic [CFG_DATA_W-1:0] offset_tempco;
    logic [CFG_DATA_W-1:0] ref_temp;
    logic [CFG_DATA_W-1:0] temp_slope;
  } coeff_t;

  // One load enable per pipeline stage
  typedef logic [NUM_STAGES-1:0] stage_en_t;

endpackage

### hdl/bsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bsc_cfg_regs
// Calibration register file: decodes register writes into the six
// calibration words. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bsc_cfg_regs
  import bsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output coeff_t                coeff
);

  // Decode and store writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_SENS_COEFF:    coeff.sens_coeff    <= wr_data;
        CFG_OFFSET_COEFF:  coeff.offset_coeff  <= wr_data;
        CFG_SENS_TEMPCO:   coeff.sens_tempco   <= wr_data;
        CFG_OFFSET_TEMPCO: coeff.offset_tempco <= wr_data;
        CFG_REF_TEMP:      coeff.ref_temp      <= wr_data;
        CFG_TEMP_SLOPE:    coeff.temp_slope    <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/bsc_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// bsc_pipe_ctrl
// Pipeline flow control: one valid bit per stage, and a load enable per
// stage that lets a stage advance when it is empty or its successor moves.
// Bubbles collapse while the output is stalled.
// ----------------------------------------------------------------------------
module bsc_pipe_ctrl
  import bsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output stage_en_t stage_en
);

  stage_en_t valid;

  // Ripple the advance condition back from the output
  always_comb begin
    stage_en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !valid[k] || stage_en[k+1];
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (stage_en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (stage_en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

### hdl/bsc_datapath.sv
// ----------------------------------------------------------------------------
// bsc_datapath
// Nine-stage compensation datapath: temperature difference, first-order
// products, second-order correction terms, corrected offset and
// sensitivity, split pressure product, and final saturation.
// ----------------------------------------------------------------------------
module bsc_datapath
  import bsc_pkg::*;
(
  input  logic                     clk,
  input  stage_en_t                stage_en,
  input  coeff_t                   coeff,
  input  logic [RAW_W-1:0]         raw_pressure,
  input  logic [RAW_W-1:0]         raw_temperature,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [PRES_W-1:0]        pressure
);

  // Stage 1: temperature difference
  logic [RAW_W-1:0]   d1_1;
  logic signed [24:0] dt_1;

  // Stage 2: products of the difference
  logic [RAW_W-1:0]   d1_2;
  logic signed [41:0] p_slope_2;
  logic signed [41:0] p_off_2;
  logic signed [41:0] p_sens_2;
  logic signed [49:0] p_dtsq_2;

  // Stage 3: first-order terms
  logic [RAW_W-1:0]   d1_3;
  logic signed [18:0] dev_3;
  logic signed [18:0] low_3;
  logic [36:0]        off_3;
  logic [35:0]        sens_3;
  logic [16:0]        t2_3;

  // Stage 4: squares and corrected temperature
  logic [RAW_W-1:0]   d1_4;
  logic signed [37:0] dev_sq_4;
  logic signed [37:0] low_sq_4;
  logic [36:0]        off_4;
  logic [35:0]        sens_4;
  logic [19:0]        temp_4;
  logic               corr_4;
  logic               low_corr_4;

  // Stage 5: second-order offset and sensitivity terms
  logic [RAW_W-1:0]   d1_5;
  logic [36:0]        off_5;
  logic [35:0]        sens_5;
  logic [38:0]        off2_5;
  logic [37:0]        sens2_5;
  logic [TEMP_W-1:0]  temp_5;

  // Stage 6: corrected offset and sensitivity
  logic [RAW_W-1:0]   d1_6;
  logic [41:0]        offc_6;
  logic [39:0]        sensc_6;
  logic [TEMP_W-1:0]  temp_6;

  // Stage 7: partial products of pressure times sensitivity
  logic [43:0]        pp_lo_7;
  logic signed [44:0] pp_hi_7;
  logic [41:0]        offc_7;
  logic [TEMP_W-1:0]  temp_7;

  // Stage 8: full product scaled down
  logic [42:0]        q_8;
  logic [41:0]        offc_8;
  logic [TEMP_W-1:0]  temp_8;

  // Combinational terms
  logic [40:0] m61;
  logic [38:0] low15;
  logic [63:0] prod;
  logic [43:0] pres_diff;
  logic [19:0] t2_sel;

  // Stage 1
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      d1_1 <= raw_pressure;
      dt_1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.ref_temp, 8'b0});
    end
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      d1_2      <= d1_1;
      p_slope_2 <= dt_1 * $signed({1'b0, coeff.temp_slope});
      p_off_2   <= dt_1 * $signed({1'b0, coeff.offset_tempco});
      p_sens_2  <= dt_1 * $signed({1'b0, coeff.sens_tempco});
      p_dtsq_2  <= dt_1 * dt_1;
    end
  end

  // Stage 3
  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      d1_3   <= d1_2;
      dev_3  <= p_slope_2[41:23];
      low_3  <= p_slope_2[41:23] + LOW_KNEE;
      off_3  <= {4'b0, coeff.offset_coeff, 17'b0}
              + {p_off_2[41], p_off_2[41:6]};
      sens_3 <= {4'b0, coeff.sens_coeff, 16'b0}
              + {p_sens_2[41], p_sens_2[41:7]};
      t2_3   <= p_dtsq_2[47:31];
    end
  end

  // Temperature correction applies only below the reference point
  assign t2_sel = dev_3[18] ? {3'b0, t2_3} : 20'd0;

  // Stage 4
  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      d1_4       <= d1_3;
      dev_sq_4   <= dev_3 * dev_3;
      low_sq_4   <= low_3 * low_3;
      off_4      <= off_3;
      sens_4     <= sens_3;
      temp_4     <= {dev_3[18], dev_3} + TEMP_REF - t2_sel;
      corr_4     <= dev_3[18];
      low_corr_4 <= low_3[18];
    end
  end

  // Constant multiples of the squares: 61x = 64x - 2x - x, 15y = 16y - y
  assign m61   = {dev_sq_4[34:0], 6'b0} - {5'b0, dev_sq_4[34:0], 1'b0}
               - {6'b0, dev_sq_4[34:0]};
  assign low15 = {low_sq_4[34:0], 4'b0} - {4'b0, low_sq_4[34:0]};

  // Stage 5
  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      d1_5   <= d1_4;
      off_5  <= off_4;
      sens_5 <= sens_4;
      if (!corr_4) begin
        off2_5  <= '0;
        sens2_5 <= '0;
      end else if (low_corr_4) begin
        off2_5  <= {2'b0, m61[40:4]} + low15;
        sens2_5 <= {2'b0, dev_sq_4[34:0], 1'b0} + {low_sq_4[34:0], 3'b0};
      end else begin
        off2_5  <= {2'b0, m61[40:4]};
        sens2_5 <= {2'b0, dev_sq_4[34:0], 1'b0};
      end
      if ($signed(temp_4) < TEMP_MIN) begin
        temp_5 <= TEMP_MIN[TEMP_W-1:0];
      end else if ($signed(temp_4) > TEMP_MAX) begin
        temp_5 <= TEMP_MAX[TEMP_W-1:0];
      end else begin
        temp_5 <= temp_4[TEMP_W-1:0];
      end
    end
  end

  // Stage 6
  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      d1_6    <= d1_5;
      offc_6  <= {{5{off_5[36]}}, off_5} - {3'b0, off2_5};
      sensc_6 <= {{4{sens_5[35]}}, sens_5} - {2'b0, sens2_5};
      temp_6  <= temp_5;
    end
  end

  // Stage 7
  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      pp_lo_7 <= d1_6 * sensc_6[19:0];
      pp_hi_7 <= $signed({1'b0, d1_6}) * $signed(sensc_6[39:20]);
      offc_7  <= offc_6;
      temp_7  <= temp_6;
    end
  end

  // Recombine the split product; the full value fits in 64 bits
  assign prod = {pp_hi_7[43:0], 20'b0} + {20'b0, pp_lo_7};

  // Stage 8
  always_ff @(posedge clk) begin
    if (stage_en[7]) begin
      q_8    <= prod[63:21];
      offc_8 <= offc_7;
      temp_8 <= temp_7;
    end
  end

  assign pres_diff = {q_8[42], q_8} - {{2{offc_8[41]}}, offc_8};

  // Stage 9: output register with pressure saturation
  always_ff @(posedge clk) begin
    if (stage_en[8]) begin
      temperature <= temp_8;
      if (pres_diff[43]) begin
        pressure <= '0;
      end else if (pres_diff[42:15] > PRES_MAX) begin
        pressure <= PRES_MAX[PRES_W-1:0];
      end else begin
        pressure <= pres_diff[31:15];
      end
    end
  end

endmodule

### hdl/baro_sensor_compensation_unit.sv
// ----------------------------------------------------------------------------
// baro_sensor_compensation_unit
// Barometer compensation: turns one raw pressure/temperature conversion pair
// into temperature in 0.01 degC and pressure in 0.01 mbar.
//
// Usage:
//   - Load the six calibration words through the cfg channel (cfg_index 0..5,
//     cfg_data low 16 bits). cfg_ready is always high; unknown indexes are
//     dropped. Write calibration only while no item is in flight.
//   - Present raw_pressure/raw_temperature with in_valid; a transfer happens
//     when in_valid and in_ready are both high.
//   - Each transfer yields one result on temperature/pressure with out_valid;
//     it leaves on a cycle with out_valid and out_ready both high.
//   - Pipeline: nine register stages, the first loaded at the input transfer
//     edge, with a split multiply and a recombine stage for the wide
//     pressure product among them.
//   - Throughput: one item per cycle while out_ready stays high.
//   - Receiver stall: stages hold their items; empty stages keep filling, so
//     in_ready drops only when every stage holds an item.
//   - Reset: clears all calibration words and empties the pipeline.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_unit
  import bsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [RAW_W-1:0]         raw_pressure,
  input  logic [RAW_W-1:0]         raw_temperature,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [TEMP_W-1:0] temperature,
  output logic [PRES_W-1:0]        pressure,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  coeff_t    coeff;
  stage_en_t stage_en;

  // Calibration writes are taken every cycle
  assign cfg_ready = 1'b1;

  bsc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .coeff    (coeff)
  );

  bsc_pipe_ctrl u_pipe_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stage_en  (stage_en)
  );

  bsc_datapath u_datapath (
    .clk             (clk),
    .stage_en        (stage_en),
    .coeff           (coeff),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .temperature     (temperature),
    .pressure        (pressure)
  );

endmodule

### tb/sv/tb_baro_sensor_compensation_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_sensor_compensation_unit
// Self-checking bench for the barometer compensation pipeline. Loads several
// calibration sets (typical, all zero, all ones, random), streams raw
// pressure/temperature pairs with random gaps on both sides, and compares
// every compensated reading against an in-bench integer predictor.
// ----------------------------------------------------------------------------
module tb_baro_sensor_compensation_unit;
  import bsc_pkg::*;

  localparam int    MAX_IDLE    = 11;
  localparam int    HOLD_CYCLES = 80;
  localparam int    PHASE_ITEMS = 240;
  localparam int    CYCLE_LIMIT = 400000;
  localparam int    MAX_PRINTS  = 40;
  localparam int    RAW_MAX     = 24'hFFFFFF;
  localparam longint WARM_EDGE  = 2000;   // 20.00 degC
  localparam longint COLD_EDGE  = -1500;  // -15.00 degC
  localparam longint TEMP_LO    = -4000;
  localparam longint TEMP_HI    = 8500;
  localparam longint PRES_HI    = 120000;

  // Indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [PRES_W-1:0]        pressure;
  } reading_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [RAW_W-1:0]         raw_pressure = '0;
  logic [RAW_W-1:0]         raw_temperature = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [TEMP_W-1:0] temperature;
  logic [PRES_W-1:0]        pressure;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  // Bench state
  coeff_t   calib = '0;
  reading_t expected_readings[$];
  bit       send_idle = 1'b1;
  bit       recv_idle = 1'b1;
  logic     rx_hold = 1'b0;
  int       rx_wait = 0;
  int       mismatches = 0;
  int       samples_sent = 0;
  int       readings_checked = 0;
  int       calib_sets = 0;
  int       cold_hits = 0;
  int       very_cold_hits = 0;
  int       cycle_count = 0;

  baro_sensor_compensation_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .temperature     (temperature),
    .pressure        (pressure),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d readings outstanding",
               cycle_count, expected_readings.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Predict one compensated reading from the current calibration
  function automatic reading_t compensate(input logic [RAW_W-1:0] p_raw,
                                          input logic [RAW_W-1:0] t_raw);
    longint d_p, d_t, c_sens, c_off, c_tcs, c_tco, c_ref, c_slope;
    longint t_delta, centi_c, offset, sensitivity;
    longint t_corr, off_corr, sens_corr, below, far_below, centi_p;
    reading_t r;
    d_p     = p_raw;
    d_t     = t_raw;
    c_sens  = calib.sens_coeff;
    c_off   = calib.offset_coeff;
    c_tcs   = calib.sens_tempco;
    c_tco   = calib.offset_tempco;
    c_ref   = calib.ref_temp;
    c_slope = calib.temp_slope;

    // First-order terms; >>> on signed values floors
    t_delta     = d_t - (c_ref <<< 8);
    centi_c     = WARM_EDGE + ((t_delta * c_slope) >>> 23);
    offset      = (c_off <<< 17) + ((t_delta * c_tco) >>> 6);
    sensitivity = (c_sens <<< 16) + ((t_delta * c_tcs) >>> 7);

    // Second-order correction below 20 degC, extra terms below -15 degC
    t_corr    = 0;
    off_corr  = 0;
    sens_corr = 0;
    if (centi_c < WARM_EDGE) begin
      cold_hits++;
      below     = centi_c - WARM_EDGE;
      t_corr    = (t_delta * t_delta) >>> 31;
      off_corr  = (61 * below * below) >>> 4;
      sens_corr = 2 * below * below;
      if (centi_c < COLD_EDGE) begin
        very_cold_hits++;
        far_below  = centi_c - COLD_EDGE;
        off_corr  += 15 * far_below * far_below;
        sens_corr += 8 * far_below * far_below;
      end
    end
    centi_c     -= t_corr;
    offset      -= off_corr;
    sensitivity -= sens_corr;

    centi_p = (((d_p * sensitivity) >>> 21) - offset) >>> 15;

    // Saturate to the output ranges
    if (centi_c < TEMP_LO) centi_c = TEMP_LO;
    if (centi_c > TEMP_HI) centi_c = TEMP_HI;
    if (centi_p < 0)       centi_p = 0;
    if (centi_p > PRES_HI) centi_p = PRES_HI;
    r.temperature = centi_c[TEMP_W-1:0];
    r.pressure    = centi_p[PRES_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Check each reading that leaves the block against the oldest prediction
  always @(posedge clk) begin : reading_check
    reading_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch($sformatf("unexpected reading T=%0d P=%0d", temperature, pressure));
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (temperature !== want.temperature)
          report_mismatch($sformatf("temperature %0d, want %0d",
                                    temperature, want.temperature));
        if (pressure !== want.pressure)
          report_mismatch($sformatf("pressure %0d, want %0d", pressure, want.pressure));
      end
    end
  end

  // Receiver pacing: random wait after each transfer, long hold on request
  always @(posedge clk) begin : rx_pacing
    int draw;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      draw = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
      rx_wait   <= draw;
      out_ready <= (draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offer one conversion pair and record its prediction on transfer
  task automatic send_sample(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
    int gap;
    gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    raw_pressure    <= p;
    raw_temperature <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_readings.push_back(compensate(p, t));
    samples_sent++;
  endtask

  // Stop offering and wait until every reading is back
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SENS_COEFF:    calib.sens_coeff    = data;
      CFG_OFFSET_COEFF:  calib.offset_coeff  = data;
      CFG_SENS_TEMPCO:   calib.sens_tempco   = data;
      CFG_OFFSET_TEMPCO: calib.offset_tempco = data;
      CFG_REF_TEMP:      calib.ref_temp      = data;
      CFG_TEMP_SLOPE:    calib.temp_slope    = data;
      default: ;
    endcase
  endtask

  task automatic load_calib(input coeff_t c);
    drain();
    write_reg(CFG_SENS_COEFF,    c.sens_coeff);
    write_reg(CFG_OFFSET_COEFF,  c.offset_coeff);
    write_reg(CFG_SENS_TEMPCO,   c.sens_tempco);
    write_reg(CFG_OFFSET_TEMPCO, c.offset_tempco);
    write_reg(CFG_REF_TEMP,      c.ref_temp);
    write_reg(CFG_TEMP_SLOPE,    c.temp_slope);
    cfg_valid <= 1'b0;
    calib_sets++;
  endtask

  function automatic coeff_t calib_words(input int c1, c2, c3, c4, c5, c6);
    coeff_t c;
    c.sens_coeff    = c1[CFG_DATA_W-1:0];
    c.offset_coeff  = c2[CFG_DATA_W-1:0];
    c.sens_tempco   = c3[CFG_DATA_W-1:0];
    c.offset_tempco = c4[CFG_DATA_W-1:0];
    c.ref_temp      = c5[CFG_DATA_W-1:0];
    c.temp_slope    = c6[CFG_DATA_W-1:0];
    return c;
  endfunction

  function automatic coeff_t typical_calib();
    return calib_words(46372, 43981, 29059, 27842, 31553, 28165);
  endfunction

  // Raw temperature relative to the reference point, clipped to 24 bits
  function automatic logic [RAW_W-1:0] near_ref(input longint delta);
    longint v;
    v = (longint'(calib.ref_temp) <<< 8) + delta;
    if (v < 0) v = 0;
    if (v > RAW_MAX) v = RAW_MAX;
    return v[RAW_W-1:0];
  endfunction

  // Random raw temperature, weighted toward the cold branches
  function automatic logic [RAW_W-1:0] pick_raw_temp();
    longint spread;
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? RAW_W'(RAW_MAX) : '0;
      1, 2, 3: return RAW_W'($urandom_range(0, RAW_MAX));
      default: begin
        spread = $urandom_range(0, 3000000);
        return near_ref(spread - 2400000);
      end
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw_pres();
    int spread;
    case ($urandom_range(0, 7))
      0:       return ($urandom_range(0, 1) != 0) ? RAW_W'(RAW_MAX) : '0;
      1, 2, 3: return RAW_W'($urandom_range(0, RAW_MAX));
      default: begin
        spread = $urandom_range(0, 3000000);
        return RAW_W'(5000000 + spread);
      end
    endcase
  endfunction

  // Reset state: all words zero, so every reading is 20.00 degC and zero pressure
  task automatic test_uncalibrated();
    send_sample('0, '0);
    send_sample(RAW_MAX, RAW_MAX);
    send_sample(RAW_W'($urandom_range(0, RAW_MAX)), RAW_W'($urandom_range(0, RAW_MAX)));
  endtask

  // Typical calibration, its worked example and the raw field corners
  task automatic test_datasheet_point();
    load_calib(typical_calib());
    send_sample(24'd6465444, 24'd8077636);
    send_sample('0, '0);
    send_sample(RAW_MAX, '0);
    send_sample('0, RAW_MAX);
    send_sample(RAW_MAX, RAW_MAX);
  endtask

  // Walk across 20 degC, -15 degC and both saturation limits
  task automatic test_temperature_corners();
    send_sample(24'd6465444, near_ref(0));
    send_sample(24'd6465444, near_ref(-1));
    send_sample(24'd6465444, near_ref(-500000));
    send_sample(24'd6465444, near_ref(-1042400));
    send_sample(24'd6465444, near_ref(-1042500));
    send_sample(24'd6465444, near_ref(-1500000));
    send_sample(24'd6465444, near_ref(-3000000));
    send_sample(24'd6465444, near_ref(2500000));
  endtask

  // Writes past the register list must leave the calibration alone
  task automatic test_unused_index();
    drain();
    write_reg(CFG_UNUSED_LO, CFG_DATA_W'($urandom_range(0, 65535)));
    write_reg(CFG_UNUSED_HI, CFG_DATA_W'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
    send_sample(24'd6465444, 24'd8077636);
    send_sample(24'd6465444, near_ref(-1500000));
  endtask

  // Hold the receiver off long enough for the pipeline to fill and stall
  task automatic test_backpressure();
    drain();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (40) send_sample(pick_raw_pres(), pick_raw_temp());
  endtask

  // Random streams under a series of calibration sets
  task automatic test_random_calibrations();
    coeff_t c;
    for (int set_no = 0; set_no < 7; set_no++) begin
      case (set_no)
        0: c = typical_calib();
        1: c = '0;
        2: c = '1;
        3: c = calib_words($urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 65535));
        4: c = calib_words(40000 + $urandom_range(0, 12000), 38000 + $urandom_range(0, 12000),
                           24000 + $urandom_range(0, 12000), 22000 + $urandom_range(0, 12000),
                           26000 + $urandom_range(0, 12000), 65535);
        5: begin
          c = typical_calib();
          c.temp_slope = '1;
          c.ref_temp   = '0;
        end
        default: begin
          c = calib_words($urandom_range(0, 65535), 0, 65535, $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
        end
      endcase
      load_calib(c);
      // Alternate paced and back-to-back stretches
      send_idle = (set_no % 2) == 0;
      recv_idle = (set_no % 2) == 0;
      repeat (PHASE_ITEMS) send_sample(pick_raw_pres(), pick_raw_temp());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_uncalibrated();
    test_datasheet_point();
    test_temperature_corners();
    test_unused_index();
    test_backpressure();
    test_random_calibrations();
    drain();

    $display("Checked %0d readings from %0d conversion pairs over %0d calibration sets",
             readings_checked, samples_sent, calib_sets);
    $display("Below 20 degC: %0d pairs, below -15 degC: %0d pairs, mismatches: %0d",
             cold_hits, very_cold_hits, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
